// ===== rtl/thba_pkg.sv =====
// shared types and constants of the tagged heap and bump allocator
package thba_pkg;

    // region geometry
    localparam int REGION_MAX_BYTES = 4096;
    localparam int TAG_BYTES        = 16;
    localparam int SPLIT_SLACK      = 8;
    localparam int USED_CAP         = (REGION_MAX_BYTES < 8191) ? REGION_MAX_BYTES : 8191;
    localparam int TAG_DEPTH        = REGION_MAX_BYTES;
    localparam int TAG_AW           = $clog2(TAG_DEPTH);

    // field widths
    localparam int SIZE_W  = 13;
    localparam int ADDR_W  = 12;
    localparam int ALIGN_W = 8;
    localparam int CFG_W   = 13;
    localparam int CFG_IW  = 2;
    localparam int STEP_W  = $clog2(SIZE_W + 1);

    // reset values of the configuration registers
    localparam logic [SIZE_W-1:0]  RESET_REGION = 13'd4096;
    localparam logic [ALIGN_W-1:0] RESET_ALIGN  = 8'd8;

    // request kinds
    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_RESET = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [1:0] STATUS_REFUSED  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_REGION = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_ALIGN  = 2'd2;

    // allocator modes
    localparam logic MODE_HEAP = 1'b0;
    localparam logic MODE_POOL = 1'b1;

    // request transaction payload
    typedef struct packed {
        logic [1:0]        kind;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] free_address;
    } req_t;

    // response transaction payload
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [1:0]        status;
        logic [SIZE_W-1:0] bytes_used;
    } rsp_t;

    // one access to the tag store
    typedef struct packed {
        logic [TAG_AW-1:0] addr;
        logic              rd;
        logic              wr_busy;
        logic              wr_len;
        logic              busy;
        logic [SIZE_W-1:0] len;
    } tag_req_t;

endpackage

// ===== rtl/thba_tag_mem.sv =====
// boundary tag store: busy flag and block length per byte offset
module thba_tag_mem
(
    input  logic                    clk,
    input  thba_pkg::tag_req_t      req,
    output logic                    rd_busy,
    output logic [thba_pkg::SIZE_W-1:0] rd_len
);

    logic                        busy_mem [thba_pkg::TAG_DEPTH];
    logic [thba_pkg::SIZE_W-1:0] len_mem  [thba_pkg::TAG_DEPTH];
    logic                        rd_busy_reg;
    logic [thba_pkg::SIZE_W-1:0] rd_len_reg;

    // busy flag array, written alone on a free
    always_ff @(posedge clk)
    begin
        if (req.wr_busy)
        begin
            busy_mem[req.addr] <= req.busy;
        end
        if (req.rd)
        begin
            rd_busy_reg <= busy_mem[req.addr];
        end
    end

    // length array
    always_ff @(posedge clk)
    begin
        if (req.wr_len)
        begin
            len_mem[req.addr] <= req.len;
        end
        if (req.rd)
        begin
            rd_len_reg <= len_mem[req.addr];
        end
    end

    assign rd_busy = rd_busy_reg;
    assign rd_len  = rd_len_reg;

endmodule

// ===== rtl/thba_rem.sv =====
// bit-serial remainder unit: request size modulo the pool granule
module thba_rem
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [thba_pkg::SIZE_W-1:0]  dividend,
    input  logic [thba_pkg::ALIGN_W-1:0] divisor,
    output logic                         done,
    output logic [thba_pkg::ALIGN_W-1:0] remainder
);

    logic [thba_pkg::STEP_W-1:0]  cnt_reg;
    logic                         done_reg;
    logic [thba_pkg::SIZE_W-1:0]  num_reg;
    logic [thba_pkg::ALIGN_W-1:0] den_reg;
    logic [thba_pkg::ALIGN_W-1:0] rem_reg;
    logic [thba_pkg::ALIGN_W:0]   trial;
    logic [thba_pkg::ALIGN_W-1:0] rem_next;

    // one restoring step: bring down the next dividend bit
    always_comb
    begin
        trial = {rem_reg, num_reg[thba_pkg::SIZE_W-1]};
        if (trial >= {1'b0, den_reg})
        begin
            trial = trial - {1'b0, den_reg};
        end
        rem_next = trial[thba_pkg::ALIGN_W-1:0];
    end

    // step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= thba_pkg::STEP_W'(thba_pkg::SIZE_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == thba_pkg::STEP_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            num_reg <= {num_reg[thba_pkg::SIZE_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/tagged_heap_and_bump_allocator.sv =====
// top level: request sequencer of the tagged heap and bump allocator
//
// One request is taken at a time. After reset the block writes the first tag before it
// takes a request. A heap allocation reads and then checks each tag visited by the
// next-fit walk, writes the free tag behind the block when the block is split, and
// then loads the response register; the walk covers at most one lap of the region. A
// pool allocation runs the bit-serial remainder unit for the padding. A free of an
// address in range clears its busy flag and a region reset rewrites the first tag; a
// free refused in pool mode and the unused kind go to the response directly. A response
// waiting in the output register does not block the next request; it only delays the
// load of the next one.
module tagged_heap_and_bump_allocator
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [thba_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [thba_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  thba_pkg::req_t               req,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output thba_pkg::rsp_t               rsp
);

    typedef enum logic [8:0] {
        S_INIT = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_DIV  = 9'b000000100,
        S_RD   = 9'b000001000,
        S_CHK  = 9'b000010000,
        S_WR2  = 9'b000100000,
        S_FREE = 9'b001000000,
        S_CLR  = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    localparam int SW = thba_pkg::SIZE_W;
    localparam int AW = thba_pkg::TAG_AW;

    state_t                         state_reg, state_next;
    logic                           mode_reg;
    logic [SW-1:0]                  region_reg;
    logic [thba_pkg::ALIGN_W-1:0]   align_reg;
    thba_pkg::req_t                 item_reg;
    logic [SW-1:0]                  cursor_reg, cursor_next;
    logic [SW-1:0]                  used_reg, used_next;
    logic [AW-1:0]                  pos_reg, pos_next;
    logic [AW-1:0]                  start_reg, start_next;
    logic                           wrapped_reg, wrapped_next;
    logic [SW-1:0]                  wlen_reg, wlen_next;
    logic [thba_pkg::ADDR_W-1:0]    res_addr_reg, res_addr_next;
    logic [1:0]                     res_status_reg, res_status_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    thba_pkg::rsp_t                 rsp_reg;

    logic                           accept;
    logic                           rsp_load;
    logic [SW-1:0]                  region_now;
    logic [SW-1:0]                  tag0_len;
    logic [thba_pkg::ALIGN_W-1:0]   granule;
    logic                           rem_start;
    logic                           rem_done;
    logic [thba_pkg::ALIGN_W-1:0]   rem_value;
    thba_pkg::tag_req_t             tag_req;
    logic                           rd_busy;
    logic [SW-1:0]                  rd_len;

    logic [SW:0]                    end_sum;
    logic [SW:0]                    tail_sum;
    logic [SW-1:0]                  delta;
    logic                           fit;
    logic                           split;
    logic [AW-1:0]                  step_pos;
    logic                           step_wrap;
    logic                           step_fail;
    logic [SW:0]                    pool_total;
    logic [SW+1:0]                  pool_end;
    logic [AW-1:0]                  free_tag;
    logic                           free_ok;

    // saturating add to the running byte count
    function automatic logic [SW-1:0] used_add(input logic [SW-1:0] base,
                                               input logic [SW:0]   amount);
        logic [SW+1:0] sum;
        sum = {2'b00, base} + {1'b0, amount};
        if (sum > (SW+2)'(thba_pkg::USED_CAP))
        begin
            return SW'(thba_pkg::USED_CAP);
        end
        return sum[SW-1:0];
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= thba_pkg::MODE_HEAP;
            region_reg <= thba_pkg::RESET_REGION;
            align_reg  <= thba_pkg::RESET_ALIGN;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                thba_pkg::CFG_MODE:   mode_reg   <= cfg_data[0];
                thba_pkg::CFG_REGION: region_reg <= cfg_data;
                thba_pkg::CFG_ALIGN:  align_reg  <= cfg_data[thba_pkg::ALIGN_W-1:0];
                default:              ;
            endcase
        end
    end

    // effective region, first tag length and pool granule
    assign region_now = (region_reg > SW'(thba_pkg::REGION_MAX_BYTES)) ?
                        SW'(thba_pkg::REGION_MAX_BYTES) : region_reg;
    assign tag0_len   = (region_now > SW'(thba_pkg::TAG_BYTES)) ?
                        region_now - SW'(thba_pkg::TAG_BYTES) : '0;
    assign granule    = (align_reg == '0) ? thba_pkg::ALIGN_W'(1) : align_reg;

    // handshakes
    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_load  = (state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall);
    assign rem_start = accept && (req.kind == thba_pkg::KIND_ALLOC) &&
                       (mode_reg == thba_pkg::MODE_POOL);

    // padding remainder
    thba_rem u_rem
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (req.request_size),
        .divisor   (granule),
        .done      (rem_done),
        .remainder (rem_value)
    );

    // tag store
    thba_tag_mem u_tag_mem
    (
        .clk     (clk),
        .req     (tag_req),
        .rd_busy (rd_busy),
        .rd_len  (rd_len)
    );

    // tag check on the data just read
    always_comb
    begin
        end_sum  = {2'b00, pos_reg} + (SW+1)'(thba_pkg::TAG_BYTES) + {1'b0, rd_len};
        tail_sum = {2'b00, pos_reg} + (SW+1)'(thba_pkg::TAG_BYTES) +
                   {1'b0, item_reg.request_size};
        delta    = rd_len - item_reg.request_size;
        fit      = !rd_busy && (item_reg.request_size <= rd_len) &&
                   (end_sum <= {1'b0, region_now});
        split    = delta > SW'(thba_pkg::TAG_BYTES + thba_pkg::SPLIT_SLACK);
        // advance past a block that does not fit, wrapping once
        if (end_sum >= {1'b0, region_now})
        begin
            step_fail = wrapped_reg;
            step_wrap = 1'b1;
            step_pos  = '0;
        end
        else
        begin
            step_fail = 1'b0;
            step_wrap = wrapped_reg;
            step_pos  = end_sum[AW-1:0];
        end
        if (step_wrap && (step_pos >= start_reg))
        begin
            step_fail = 1'b1;
        end
    end

    // pool bump and free target
    always_comb
    begin
        pool_total = {1'b0, item_reg.request_size} + (SW+1)'(granule) - (SW+1)'(rem_value);
        pool_end   = {2'b00, cursor_reg} + {1'b0, pool_total};
        free_tag   = item_reg.free_address - AW'(thba_pkg::TAG_BYTES);
        free_ok    = (item_reg.free_address >= thba_pkg::ADDR_W'(thba_pkg::TAG_BYTES)) &&
                     ({1'b0, free_tag} < region_now);
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        used_next       = used_reg;
        pos_next        = pos_reg;
        start_next      = start_reg;
        wrapped_next    = wrapped_reg;
        wlen_next       = wlen_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        tag_req         = '0;
        tag_req.addr    = pos_reg;

        unique case (state_reg)
            S_INIT:
            begin
                tag_req.addr    = '0;
                tag_req.wr_busy = 1'b1;
                tag_req.wr_len  = 1'b1;
                tag_req.busy    = 1'b0;
                tag_req.len     = tag0_len;
                state_next      = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    res_addr_next   = '0;
                    res_status_next = thba_pkg::STATUS_OK;
                    case (req.kind)
                        thba_pkg::KIND_ALLOC:
                        begin
                            if (mode_reg == thba_pkg::MODE_POOL)
                            begin
                                state_next = S_DIV;
                            end
                            else
                            begin
                                pos_next     = (cursor_reg >= region_now) ? '0 :
                                               cursor_reg[AW-1:0];
                                start_next   = pos_next;
                                wrapped_next = 1'b0;
                                state_next   = S_RD;
                            end
                        end
                        thba_pkg::KIND_FREE:
                        begin
                            if (mode_reg == thba_pkg::MODE_POOL)
                            begin
                                res_status_next = thba_pkg::STATUS_REFUSED;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_FREE;
                            end
                        end
                        thba_pkg::KIND_RESET:
                        begin
                            state_next = S_CLR;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (rem_done)
                begin
                    if (pool_end > (SW+2)'(region_now))
                    begin
                        res_status_next = thba_pkg::STATUS_NO_SPACE;
                    end
                    else
                    begin
                        res_addr_next = cursor_reg[thba_pkg::ADDR_W-1:0];
                        cursor_next   = pool_end[SW-1:0];
                        used_next     = used_add(used_reg, pool_total);
                    end
                    state_next = S_DONE;
                end
            end
            S_RD:
            begin
                tag_req.rd = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (fit)
                begin
                    res_addr_next   = thba_pkg::ADDR_W'(pos_reg + AW'(thba_pkg::TAG_BYTES));
                    tag_req.wr_busy = 1'b1;
                    tag_req.busy    = 1'b1;
                    if (split)
                    begin
                        tag_req.wr_len = 1'b1;
                        tag_req.len    = item_reg.request_size;
                        pos_next       = tail_sum[AW-1:0];
                        wlen_next      = delta - SW'(thba_pkg::TAG_BYTES);
                        cursor_next    = {1'b0, tail_sum[AW-1:0]};
                        used_next      = used_add(used_reg,
                                         {1'b0, item_reg.request_size} +
                                         (SW+1)'(thba_pkg::TAG_BYTES));
                        state_next     = S_WR2;
                    end
                    else
                    begin
                        cursor_next = (end_sum >= {1'b0, region_now}) ? '0 : end_sum[SW-1:0];
                        used_next   = used_add(used_reg, {1'b0, item_reg.request_size});
                        state_next  = S_DONE;
                    end
                end
                else if (step_fail)
                begin
                    res_status_next = thba_pkg::STATUS_NO_SPACE;
                    state_next      = S_DONE;
                end
                else
                begin
                    pos_next     = step_pos;
                    wrapped_next = step_wrap;
                    state_next   = S_RD;
                end
            end
            S_WR2:
            begin
                // free tag behind the split-off payload
                tag_req.wr_busy = 1'b1;
                tag_req.wr_len  = 1'b1;
                tag_req.busy    = 1'b0;
                tag_req.len     = wlen_reg;
                state_next      = S_DONE;
            end
            S_FREE:
            begin
                tag_req.addr    = free_tag;
                tag_req.wr_busy = free_ok;
                tag_req.busy    = 1'b0;
                state_next      = S_DONE;
            end
            S_CLR:
            begin
                tag_req.addr    = '0;
                tag_req.wr_busy = 1'b1;
                tag_req.wr_len  = 1'b1;
                tag_req.busy    = 1'b0;
                tag_req.len     = tag0_len;
                cursor_next     = '0;
                used_next       = '0;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // response register valid
    assign rsp_valid_next = rsp_load || (rsp_valid_reg && rsp_stall);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            cursor_reg     <= '0;
            used_reg       <= '0;
            pos_reg        <= '0;
            start_reg      <= '0;
            wrapped_reg    <= 1'b0;
            res_status_reg <= thba_pkg::STATUS_OK;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            used_reg       <= used_next;
            pos_reg        <= pos_next;
            start_reg      <= start_next;
            wrapped_reg    <= wrapped_next;
            res_status_reg <= res_status_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
        wlen_reg     <= wlen_next;
        res_addr_reg <= res_addr_next;
        if (rsp_load)
        begin
            rsp_reg.address    <= res_addr_reg;
            rsp_reg.status     <= res_status_reg;
            rsp_reg.bytes_used <= used_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/thba_checker.sv =====
// port-level checks of the allocator and their binding to the top level
module thba_port_checks
(
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input thba_pkg::rsp_t rsp
);

    // a stalled response transaction holds
    property p_rsp_hold;
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp);
    endproperty
    a_rsp_hold: assert property (p_rsp_hold)
        else $error("response changed while stalled");

    // one request in flight: the input stalls right after a transaction
    property p_one_in_flight;
        @(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall;
    endproperty
    a_one_in_flight: assert property (p_one_in_flight)
        else $error("request taken while another is in flight");

    // failed or refused requests report offset zero
    property p_fail_addr;
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != thba_pkg::STATUS_OK) |-> rsp.address == '0;
    endproperty
    a_fail_addr: assert property (p_fail_addr)
        else $error("nonzero offset on a failed request");

    // status code and byte count stay in range
    property p_rsp_range;
        @(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status <= thba_pkg::STATUS_REFUSED) &&
                      (rsp.bytes_used <= thba_pkg::SIZE_W'(thba_pkg::USED_CAP));
    endproperty
    a_rsp_range: assert property (p_rsp_range)
        else $error("response status or byte count out of range");

endmodule

bind tagged_heap_and_bump_allocator thba_port_checks u_thba_port_checks
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
